// ----- design/hgdb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgdb_pkg
// shared types, constants and helpers of the haar gradient descriptor binner
// ----------------------------------------------------------------------------
package hgdb_pkg;

    localparam int GRID_SIDE   = 20;
    localparam int CELL_SIDE   = 5;
    localparam int NUM_POINTS  = GRID_SIDE * GRID_SIDE;
    localparam int CELLS_ROW   = GRID_SIDE / CELL_SIDE;
    localparam int NUM_CELLS   = CELLS_ROW * CELLS_ROW;
    localparam int NUM_ENTRIES = NUM_CELLS * 4;
    localparam int ACC_W       = 46;
    localparam int WIDE_W      = 56;
    localparam int TOTAL_W     = 38;
    localparam int QUOT_W      = 31;

    localparam logic [2:0] CFG_SHIFT   = 3'd0;
    localparam logic [2:0] CFG_GAIN    = 3'd1;
    localparam logic [2:0] CFG_ABS_W   = 3'd2;
    localparam logic [2:0] CFG_SIMPLE  = 3'd3;
    localparam logic [2:0] CFG_TEXTURE = 3'd4;

    typedef struct packed {
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [15:0] gauss_weight;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] descriptor_value;
        logic               last;
    } t_out_item;

    typedef enum logic [11:0] {
        S_LOAD    = 12'b0000_0000_0001,
        S_WRWAIT  = 12'b0000_0000_0010,
        S_LIMIT   = 12'b0000_0000_0100,
        S_BIN     = 12'b0000_0000_1000,
        S_DRAIN   = 12'b0000_0001_0000,
        S_ENTRY   = 12'b0000_0010_0000,
        S_ENTWAIT = 12'b0000_0100_0000,
        S_DIVINIT = 12'b0000_1000_0000,
        S_DIV     = 12'b0001_0000_0000,
        S_ERD     = 12'b0010_0000_0000,
        S_EMUL    = 12'b0100_0000_0000,
        S_EOUT    = 12'b1000_0000_0000
    } t_state;

    typedef struct packed {
        logic       in_take;
        logic [8:0] wr_addr;
        logic       load_limit;
        logic       clear_acc;
        logic       bin_issue;
        logic [3:0] cell_idx;
        logic [3:0] dx;
        logic [3:0] dy;
        logic       ent_go;
        logic [1:0] ent_k;
        logic       div_init;
        logic       div_step;
        logic       div_first;
        logic       ent_read;
        logic [5:0] ent_idx;
        logic       mul_go;
        logic       load_out;
        logic       out_last;
    } t_cmd;

    typedef struct packed {
        logic simple;
        logic out_free;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(32'sh7FFF_FFFF);
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- design/hgdb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgdb_ctrl
// sequencer: load, clip and bin, entry forming, reciprocal, emission
// ----------------------------------------------------------------------------
module hgdb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  hgdb_pkg::t_stat i_stat,
    output hgdb_pkg::t_cmd  o_cmd,
    output logic          o_in_stall
);
    import hgdb_pkg::*;

    t_state     r_state, n_state;
    logic [8:0] r_count, n_count;
    logic [3:0] r_cell, n_cell;
    logic [3:0] r_dx, n_dx;
    logic [3:0] r_dy, n_dy;
    logic [1:0] r_drain, n_drain;
    logic [1:0] r_k, n_k;
    logic [4:0] r_div, n_div;
    logic [5:0] r_idx, n_idx;
    logic [3:0] lo, hi;
    logic       take;

    assign lo         = i_stat.simple ? 4'd3 : 4'd1;
    assign hi         = i_stat.simple ? 4'd7 : 4'd9;
    assign o_in_stall = (r_state != S_LOAD);
    assign take       = i_in_valid && (r_state == S_LOAD);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_cell  = r_cell;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_drain = r_drain;
        n_k     = r_k;
        n_div   = r_div;
        n_idx   = r_idx;

        o_cmd            = '0;
        o_cmd.in_take    = take;
        o_cmd.wr_addr    = r_count;
        o_cmd.cell_idx   = r_cell;
        o_cmd.dx         = r_dx;
        o_cmd.dy         = r_dy;
        o_cmd.ent_k      = r_k;
        o_cmd.div_first  = (r_div == 5'd0);
        o_cmd.ent_idx    = r_idx;
        o_cmd.out_last   = (r_idx == 6'(NUM_ENTRIES - 1));

        unique case (r_state)
            S_LOAD: begin
                if (take) begin
                    if (r_count == 9'(NUM_POINTS - 1)) begin
                        n_count = '0;
                        n_state = S_WRWAIT;
                    end else begin
                        n_count = r_count + 9'd1;
                    end
                end
            end
            S_WRWAIT: begin
                n_state = S_LIMIT;
            end
            S_LIMIT: begin
                o_cmd.load_limit = 1'b1;
                o_cmd.clear_acc  = 1'b1;
                n_cell  = '0;
                n_dx    = lo;
                n_dy    = lo;
                n_state = S_BIN;
            end
            S_BIN: begin
                o_cmd.bin_issue = 1'b1;
                if (r_dx == hi) begin
                    n_dx = lo;
                    if (r_dy == hi) begin
                        n_drain = '0;
                        n_state = S_DRAIN;
                    end else begin
                        n_dy = r_dy + 4'd1;
                    end
                end else begin
                    n_dx = r_dx + 4'd1;
                end
            end
            S_DRAIN: begin
                n_drain = r_drain + 2'd1;
                if (r_drain == 2'd2) begin
                    n_k     = '0;
                    n_state = S_ENTRY;
                end
            end
            S_ENTRY: begin
                o_cmd.ent_go = 1'b1;
                n_k = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    o_cmd.clear_acc = 1'b1;
                    if (r_cell == 4'(NUM_CELLS - 1)) begin
                        n_state = S_ENTWAIT;
                    end else begin
                        n_cell  = r_cell + 4'd1;
                        n_dx    = lo;
                        n_dy    = lo;
                        n_state = S_BIN;
                    end
                end
            end
            S_ENTWAIT: begin
                n_state = S_DIVINIT;
            end
            S_DIVINIT: begin
                o_cmd.div_init = 1'b1;
                n_div   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div = r_div + 5'd1;
                if (r_div == 5'(QUOT_W - 1)) begin
                    n_idx   = '0;
                    n_state = S_ERD;
                end
            end
            S_ERD: begin
                o_cmd.ent_read = 1'b1;
                n_state = S_EMUL;
            end
            S_EMUL: begin
                o_cmd.mul_go = 1'b1;
                n_state = S_EOUT;
            end
            S_EOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_idx = r_idx + 6'd1;
                    if (r_idx == 6'(NUM_ENTRIES - 1)) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_cell  <= '0;
            r_dx    <= '0;
            r_dy    <= '0;
            r_drain <= '0;
            r_k     <= '0;
            r_div   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cell  <= n_cell;
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_drain <= n_drain;
            r_k     <= n_k;
            r_div   <= n_div;
            r_idx   <= n_idx;
        end
    end

endmodule

// ----- design/hgdb_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgdb_dp
// datapath: sample weighting and store, clip and bin, entries, divider, output
// ----------------------------------------------------------------------------
module hgdb_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hgdb_pkg::t_in_item i_in_data,
    input  hgdb_pkg::t_cmd    i_cmd,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [9:0]        i_cfg_data,
    input  logic              i_out_stall,
    output hgdb_pkg::t_stat   o_stat,
    output logic              o_out_valid,
    output hgdb_pkg::t_out_item o_out_data
);
    import hgdb_pkg::*;

    // configuration
    logic [4:0] r_shift;
    logic [9:0] r_gain;
    logic [7:0] r_abs_w;
    logic       r_simple;
    logic       r_texture;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift   <= '0;
            r_gain    <= 10'd100;
            r_abs_w   <= 8'd5;
            r_simple  <= 1'b0;
            r_texture <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SHIFT:   r_shift   <= i_cfg_data[4:0];
                CFG_GAIN:    r_gain    <= i_cfg_data;
                CFG_ABS_W:   r_abs_w   <= i_cfg_data[7:0];
                CFG_SIMPLE:  r_simple  <= i_cfg_data[0];
                CFG_TEXTURE: r_texture <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input weighting
    logic signed [31:0] gx, gy;
    logic signed [9:0]  wg;
    logic signed [41:0] px, py;
    logic signed [31:0] r_vx, r_vy;
    logic               r_wv;
    logic [8:0]         r_wa;

    assign gx = i_in_data.grad_x >>> r_shift;
    assign gy = i_in_data.grad_y >>> r_shift;
    assign wg = 10'(i_in_data.gauss_weight >>> 6);
    assign px = 42'(gx) * 42'(wg);
    assign py = 42'(gy) * 42'(wg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
        end else begin
            r_wv <= i_cmd.in_take;
        end
        if (i_cmd.in_take) begin
            r_vx <= px[41:10];
            r_vy <= py[41:10];
            r_wa <= i_cmd.wr_addr;
        end
    end

    // sample store and magnitude sum
    logic signed [31:0] mem_x [NUM_POINTS];
    logic signed [31:0] mem_y [NUM_POINTS];
    logic [31:0]        r_mag;
    logic [31:0]        ax_in, ay_in;
    logic [33:0]        mag_sum;
    logic [31:0]        r_limit;

    assign ax_in   = r_vx[31] ? 32'(-r_vx) : 32'(r_vx);
    assign ay_in   = r_vy[31] ? 32'(-r_vy) : 32'(r_vy);
    assign mag_sum = 34'(r_mag) + 34'(ax_in) + 34'(ay_in);

    always_ff @(posedge i_clk) begin
        if (r_wv) begin
            mem_x[r_wa] <= r_vx;
            mem_y[r_wa] <= r_vy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag <= '0;
        end else if (i_cmd.load_limit) begin
            r_mag <= '0;
        end else if (r_wv) begin
            r_mag <= (mag_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : mag_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_limit) begin
            r_limit <= 32'(r_mag[31:10]) * 32'(r_gain);
        end
    end

    // bin point address and weight
    logic [5:0] pt_x, pt_y;
    logic [2:0] wx, wy;
    logic [4:0] wt;
    logic [8:0] rd_addr;
    logic       pt_ok;

    assign pt_x = 6'({4'd0, i_cmd.cell_idx[1:0]} * 6'(CELL_SIDE)) + {2'd0, i_cmd.dx} - 6'd3;
    assign pt_y = 6'({4'd0, i_cmd.cell_idx[3:2]} * 6'(CELL_SIDE)) + {2'd0, i_cmd.dy} - 6'd3;
    assign wx   = r_simple ? 3'd1 : ((i_cmd.dx <= 4'd5) ? i_cmd.dx[2:0] : 3'(4'd10 - i_cmd.dx));
    assign wy   = r_simple ? 3'd1 : ((i_cmd.dy <= 4'd5) ? i_cmd.dy[2:0] : 3'(4'd10 - i_cmd.dy));
    assign wt   = 5'({2'd0, wx} * {2'd0, wy});
    assign rd_addr = 9'({pt_y, 4'd0}) + 9'({pt_y, 2'd0}) + 9'(pt_x);
    assign pt_ok = i_cmd.bin_issue && (pt_x < 6'(GRID_SIDE)) && (pt_y < 6'(GRID_SIDE));

    logic signed [31:0] r_rx, r_ry;
    logic               r_p1_v, r_p2_v, r_p3_v;
    logic [4:0]         r_p1_w, r_p2_w;

    always_ff @(posedge i_clk) begin
        if (pt_ok) begin
            r_rx <= mem_x[rd_addr];
            r_ry <= mem_y[rd_addr];
        end
        r_p1_w <= wt;
    end

    // clip stage
    function automatic logic signed [31:0] clip(input logic signed [31:0] v,
                                                input logic [31:0] lim);
        logic signed [33:0] ve, lp;
        ve = 34'(v);
        lp = $signed({2'b00, lim});
        if (ve > lp) begin
            return lp[31:0];
        end else if (ve < -lp) begin
            return 32'(-lp);
        end
        return v;
    endfunction

    logic signed [31:0] r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        r_cx   <= clip(r_rx, r_limit);
        r_cy   <= clip(r_ry, r_limit);
        r_p2_w <= r_p1_w;
    end

    // weighting stage
    logic [31:0]        acx, acy;
    logic signed [5:0]  ws;
    logic signed [38:0] r_qx, r_qy, r_qax, r_qay;

    assign acx = r_cx[31] ? 32'(-r_cx) : 32'(r_cx);
    assign acy = r_cy[31] ? 32'(-r_cy) : 32'(r_cy);
    assign ws  = $signed({1'b0, r_p2_w});

    always_ff @(posedge i_clk) begin
        r_qx  <= 39'(r_cx) * 39'(ws);
        r_qy  <= 39'(r_cy) * 39'(ws);
        r_qax <= 39'($signed({1'b0, acx})) * 39'(ws);
        r_qay <= 39'($signed({1'b0, acy})) * 39'(ws);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
        end else begin
            r_p1_v <= pt_ok;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
        end
    end

    // cell accumulators
    logic signed [ACC_W-1:0] r_acc_sx, r_acc_sy, r_acc_ax, r_acc_ay;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_acc) begin
            r_acc_sx <= '0;
            r_acc_sy <= '0;
            r_acc_ax <= '0;
            r_acc_ay <= '0;
        end else if (r_p3_v) begin
            r_acc_sx <= r_acc_sx + ACC_W'(r_qx);
            r_acc_sy <= r_acc_sy + ACC_W'(r_qy);
            r_acc_ax <= r_acc_ax + ACC_W'(r_qax);
            r_acc_ay <= r_acc_ay + ACC_W'(r_qay);
        end
    end

    // entry forming
    logic signed [ACC_W-1:0]  base, net, net_abs;
    logic signed [ACC_W:0]    tex;
    logic signed [WIDE_W-1:0] wide;
    logic signed [31:0]       r_ent;
    logic                     r_ent_v;
    logic [5:0]               r_ent_addr;

    always_comb begin
        case (i_cmd.ent_k)
            2'd0:    base = r_acc_sx;
            2'd1:    base = r_acc_sy;
            2'd2:    base = r_acc_ax;
            default: base = r_acc_ay;
        endcase
        net     = i_cmd.ent_k[0] ? r_acc_sy : r_acc_sx;
        net_abs = net[ACC_W-1] ? -net : net;
        tex     = (ACC_W + 1)'(base) - (r_texture ? (ACC_W + 1)'(net_abs) : '0);
        if (r_simple) begin
            wide = WIDE_W'(base);
        end else if (!i_cmd.ent_k[1]) begin
            wide = WIDE_W'(base) <<< 3;
        end else begin
            wide = WIDE_W'(tex) * WIDE_W'($signed({1'b0, r_abs_w}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_v <= 1'b0;
        end else begin
            r_ent_v <= i_cmd.ent_go;
        end
        r_ent      <= sat32(wide);
        r_ent_addr <= {i_cmd.cell_idx, i_cmd.ent_k};
    end

    logic signed [31:0] ent_mem [NUM_ENTRIES];
    logic [TOTAL_W-1:0] r_total;
    logic [32:0]        ent_abs;

    assign ent_abs = r_ent[31] ? 33'(-34'(r_ent)) : 33'(r_ent);

    always_ff @(posedge i_clk) begin
        if (r_ent_v) begin
            ent_mem[r_ent_addr] <= r_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.load_limit) begin
            r_total <= '0;
        end else if (r_ent_v) begin
            r_total <= r_total + TOTAL_W'(ent_abs);
        end
    end

    // restoring divider for 2^30 / total, one quotient bit per cycle
    logic [TOTAL_W:0]   r_rem, rem_sh;
    logic [QUOT_W-1:0]  r_quot;
    logic               fits;

    assign rem_sh = {r_rem[TOTAL_W-1:0], i_cmd.div_first};
    assign fits   = rem_sh >= {1'b0, r_total};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= fits ? rem_sh - {1'b0, r_total} : rem_sh;
            r_quot <= {r_quot[QUOT_W-2:0], fits};
        end
    end

    // emission
    logic signed [31:0] r_rd_ent;
    logic signed [31:0] recip;
    logic signed [63:0] r_prod;
    logic               r_out_v;
    t_out_item          r_out;

    assign recip = (r_total == '0) ? 32'sd0 : $signed({1'b0, r_quot});

    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_read) begin
            r_rd_ent <= ent_mem[i_cmd.ent_idx];
        end
        if (i_cmd.mul_go) begin
            r_prod <= 64'(r_rd_ent) * 64'(recip);
        end
        if (i_cmd.load_out) begin
            r_out.descriptor_value <= r_prod[37:6];
            r_out.last             <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_out_data      = r_out;
    assign o_stat.simple   = r_simple;
    assign o_stat.out_free = !r_out_v || !i_out_stall;

endmodule

// ----- design/haar_gradient_descriptor_binning_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haar_gradient_descriptor_binning_unit
// 64-entry haar gradient descriptor from a 20x20 grid of weighted gradients
// ----------------------------------------------------------------------------
// The unit takes one grid sample per cycle while loading (400 transfers per
// descriptor). After the last sample it goes busy and stalls its input: the
// clip limit is formed, then each of the 16 cells is built by walking its
// support through the single read port of the sample store, one sample
// read per cycle (81 points per cell bilinear, 25 in simple-sum mode),
// followed by a pipeline drain and entry forming. A serial restoring
// divider forms the reciprocal of the L1 sum, and the 64 entries then
// leave one at a time: each is read, multiplied and loaded into the
// output register before the next is read, and a full output register
// under stall holds the next one back. The input is taken again as soon
// as the last entry sits in the output register.
// ----------------------------------------------------------------------------
module haar_gradient_descriptor_binning_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // sample input
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hgdb_pkg::t_in_item  i_in_data,
    // descriptor output
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hgdb_pkg::t_out_item o_out_data,
    // configuration writes
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [9:0]          i_cfg_data
);
    import hgdb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    hgdb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // storage and arithmetic
    hgdb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // the final entry is never followed directly by another one
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.last) |=> !o_out_valid)
        else $error("output valid right after the final entry transfer");

    // while samples are taken only the final entry may still wait
    a_load_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall && o_out_valid) |-> o_out_data.last)
        else $error("input open while descriptor emission unfinished");

    // busy phase never stores a new output while one waits under stall
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("waiting output entry lost");

endmodule

// ----- sim/hgdb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgdb_checker
// descriptor predictor and scoreboard for the haar gradient binning unit
// ----------------------------------------------------------------------------
// Watches the sample, descriptor and configuration ports. A private copy of
// the configuration and the sample store forms the 64 expected entries when
// the 400th sample of a grid is taken; accepted outputs are compared in order.
// ----------------------------------------------------------------------------
module hgdb_checker
    import hgdb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_item   i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_item  i_out_data,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [9:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    logic [4:0] shift_amt;
    logic [9:0] clip_gain;
    logic [7:0] abs_gain;
    logic       simple_mode;
    logic       texture_mode;

    logic signed [31:0] grid_x [NUM_POINTS];
    logic signed [31:0] grid_y [NUM_POINTS];
    longint unsigned    mag_sum;
    int                 grid_count;
    longint             cell_sum [NUM_ENTRIES];

    t_out_item entry_q[$];
    int        fails;

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void bin_add(input int row, input int col, input longint w,
                                    input longint vx, input longint vy);
        int c;
        if (row < 0 || col < 0 || row >= CELLS_ROW || col >= CELLS_ROW) return;
        c = (row * CELLS_ROW + col) * 4;
        cell_sum[c]     += w * vx;
        cell_sum[c + 1] += w * vy;
        cell_sum[c + 2] += w * mag(vx);
        cell_sum[c + 3] += w * mag(vy);
    endfunction

    // clip, bin, normalize and queue the 64 entries
    function automatic void form_descriptor();
        longint    limit;
        longint    vx;
        longint    vy;
        longint    ax;
        longint    ay;
        longint    total;
        longint    recip;
        longint    scaled;
        longint    ent [NUM_ENTRIES];
        int        a;
        int        b;
        int        fx;
        int        fy;
        t_out_item r;
        limit = longint'(mag_sum >> 10) * longint'(clip_gain);
        for (int i = 0; i < NUM_ENTRIES; i++) cell_sum[i] = 0;
        for (int y = 0; y < GRID_SIDE; y++) begin
            for (int x = 0; x < GRID_SIDE; x++) begin
                vx = grid_x[y * GRID_SIDE + x];
                vy = grid_y[y * GRID_SIDE + x];
                if (vx > limit) vx = limit; else if (vx < -limit) vx = -limit;
                if (vy > limit) vy = limit; else if (vy < -limit) vy = -limit;
                if (simple_mode) begin
                    bin_add(y / CELL_SIDE, x / CELL_SIDE, 1, vx, vy);
                end else begin
                    a = (x + 3) / 5;
                    fx = (x + 3) % 5;
                    b = (y + 3) / 5;
                    fy = (y + 3) % 5;
                    if (x >= 2 && y >= 2) bin_add(b - 1, a - 1, (5 - fy) * (5 - fx), vx, vy);
                    if (x < 17 && y >= 2) bin_add(b - 1, a, (5 - fy) * fx, vx, vy);
                    if (x >= 2 && y < 17) bin_add(b, a - 1, fy * (5 - fx), vx, vy);
                    if (x < 17 && y < 17) bin_add(b, a, fy * fx, vx, vy);
                end
            end
        end
        total = 0;
        for (int i = 0; i < NUM_CELLS; i++) begin
            if (simple_mode) begin
                for (int k = 0; k < 4; k++) ent[i * 4 + k] = clamp32(cell_sum[i * 4 + k]);
            end else begin
                ax = cell_sum[i * 4 + 2];
                ay = cell_sum[i * 4 + 3];
                if (texture_mode) begin
                    ax -= mag(cell_sum[i * 4]);
                    ay -= mag(cell_sum[i * 4 + 1]);
                end
                ent[i * 4]     = clamp32(cell_sum[i * 4] * 8);
                ent[i * 4 + 1] = clamp32(cell_sum[i * 4 + 1] * 8);
                ent[i * 4 + 2] = clamp32(ax * longint'(abs_gain));
                ent[i * 4 + 3] = clamp32(ay * longint'(abs_gain));
            end
        end
        for (int i = 0; i < NUM_ENTRIES; i++) total += mag(ent[i]);
        // an all-zero descriptor has no reciprocal
        recip = (total != 0) ? (64'sd1 << 30) / total : 0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            scaled = (ent[i] * recip) >>> 6;
            r.descriptor_value = scaled[31:0];
            r.last = (i == NUM_ENTRIES - 1);
            entry_q.push_back(r);
        end
        grid_count = 0;
        mag_sum = 0;
    endfunction

    function automatic void take_sample(input t_in_item it);
        longint gx;
        longint gy;
        longint wg;
        longint vx;
        longint vy;
        gx = longint'(it.grad_x) >>> shift_amt;
        gy = longint'(it.grad_y) >>> shift_amt;
        wg = longint'(it.gauss_weight) >>> 6;
        vx = (gx * wg) >>> 10;
        vy = (gy * wg) >>> 10;
        if (grid_count >= NUM_POINTS) grid_count = 0;
        grid_x[grid_count] = vx[31:0];
        grid_y[grid_count] = vy[31:0];
        // running magnitude saturates at 32 bits
        mag_sum = mag_sum + longint'(mag(vx)) + longint'(mag(vy));
        if (mag_sum > 64'hFFFF_FFFF) mag_sum = 64'hFFFF_FFFF;
        grid_count++;
        if (grid_count >= NUM_POINTS) form_descriptor();
    endfunction

    function automatic void check_entry(input t_out_item got);
        t_out_item want;
        if (entry_q.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("unexpected descriptor entry %0d last %0b",
                         got.descriptor_value, got.last);
            return;
        end
        want = entry_q.pop_front();
        if (got.descriptor_value !== want.descriptor_value) begin
            fails++;
            if (fails <= 10)
                $display("descriptor_value mismatch: expected %0d actual %0d",
                         want.descriptor_value, got.descriptor_value);
        end
        if (got.last !== want.last) begin
            fails++;
            if (fails <= 10)
                $display("last mismatch: expected %0b actual %0b", want.last, got.last);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shift_amt    = 5'd0;
            clip_gain    = 10'd100;
            abs_gain     = 8'd5;
            simple_mode  = 1'b0;
            texture_mode = 1'b0;
            mag_sum      = 0;
            grid_count   = 0;
            entry_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SHIFT:   shift_amt    = i_cfg_data[4:0];
                    CFG_GAIN:    clip_gain    = i_cfg_data;
                    CFG_ABS_W:   abs_gain     = i_cfg_data[7:0];
                    CFG_SIMPLE:  simple_mode  = i_cfg_data[0];
                    CFG_TEXTURE: texture_mode = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) check_entry(i_out_data);
            if (i_in_valid && !i_in_stall) take_sample(i_in_data);
        end
        o_fail_count <= fails;
        o_pending    <= entry_q.size();
    end

endmodule

// ----- sim/tb_haar_gradient_descriptor_binning_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_haar_gradient_descriptor_binning_unit
// stimulus and verdict for the haar gradient descriptor binning unit
// ----------------------------------------------------------------------------
// Sends whole 20x20 grids under a series of register settings (both binning
// modes, texture on and off, clip gain and shift extremes, an all-zero grid)
// with random idling on both channels. A long output hold-off lets the unit
// fill up and stall its input. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_haar_gradient_descriptor_binning_unit;
    import hgdb_pkg::*;

    localparam logic [2:0] CFG_SPARE_5 = 3'd5;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         NUM_GRIDS   = 8;

    // grid flavors
    localparam int MIX_GRID   = 0;
    localparam int LOUD_GRID  = 1;
    localparam int QUIET_GRID = 2;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;
    logic       i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [9:0] i_cfg_data;

    int fail_count;
    int pending;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    logic hold_arm;
    logic hold_done;
    int hold_left;

    haar_gradient_descriptor_binning_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    hgdb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock, low first so no rising edge falls at time zero
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stall, plus one long hold-off once the armed grid
    // starts to come out, so the unit backs up while the next grid is offered
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_arm && !hold_done && o_out_valid) begin
            hold_left   <= 600;
            hold_done   <= 1'b1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic [31:0] pick_grad(input int flavor);
        int r;
        r = $urandom_range(9);
        if (flavor == LOUD_GRID && r > 3) r = $urandom_range(3);
        case (r)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4, 5, 6: return $urandom;
            default: return 32'($urandom_range(4095)) - 32'd2048;
        endcase
    endfunction

    function automatic logic [15:0] pick_weight(input int flavor);
        logic [31:0] r;
        // weights below 64 vanish after the internal shift
        if (flavor == QUIET_GRID) return 16'($urandom_range(63));
        r = $urandom;
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(63));
            default: return r[15:0];
        endcase
    endfunction

    function automatic t_in_item pick_sample(input int flavor);
        t_in_item it;
        it.grad_x       = pick_grad(flavor);
        it.grad_y       = pick_grad(flavor);
        it.gauss_weight = pick_weight(flavor);
        return it;
    endfunction

    // one transfer on the sample channel, with an optional idle gap before it
    task automatic send_sample(input t_in_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // sender pause: let every expected entry arrive, then let the unit settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // one write, with the enable dropped again before the next write
    task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [9:0] sh, input logic [9:0] gain,
                            input logic [9:0] aw, input logic [9:0] simple,
                            input logic [9:0] tex);
        write_reg(CFG_SHIFT, sh);
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_ABS_W, aw);
        write_reg(CFG_SIMPLE, simple);
        write_reg(CFG_TEXTURE, tex);
    endtask

    t_in_item corner [12];
    int       flavor;

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_data     <= '0;
        i_out_stall   <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_SHIFT;
        i_cfg_data    <= '0;
        hold_arm      <= 1'b0;
        hold_done     <= 1'b0;
        hold_left     <= 0;
        cycles        <= 0;
        send_idle_pct = 13;
        recv_idle_pct = 58;

        // field extremes and sign corners opening the first grid
        corner[0]  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF};
        corner[1]  = '{32'h8000_0000, 32'h8000_0000, 16'h8000};
        corner[2]  = '{32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF};
        corner[3]  = '{32'h7FFF_FFFF, 32'h8000_0000, 16'h8000};
        corner[4]  = '{32'h0, 32'h0, 16'h0};
        corner[5]  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF};
        corner[6]  = '{32'h1, 32'hFFFF_FFFF, 16'h0040};
        corner[7]  = '{32'h0000_FFFF, 32'hFFFF_0000, 16'h003F};
        corner[8]  = '{32'h5555_5555, 32'hAAAA_AAAA, 16'h5555};
        corner[9]  = '{32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA};
        corner[10] = '{32'h0000_0400, 32'hFFFF_FC00, 16'hFFC0};
        corner[11] = '{32'h7FFF_FFFF, 32'h0, 16'h7FFF};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int g = 0; g < NUM_GRIDS; g++) begin
            flavor = MIX_GRID;
            // settings change only with the unit idle; grid 5 follows grid 4
            // straight away so the hold-off backs the unit up
            if (g != 0 && g != 5) drain();
            case (g)
                1: set_regs(10'd24, 10'd1023, 10'd255, 10'd0, 10'd1);
                2: begin
                    // zero clip gain: every entry is zero; spare indexes ignored
                    set_regs(10'd0, 10'd0, 10'd0, 10'd1, 10'd0);
                    write_reg(CFG_SPARE_5, 10'h3FF);
                    write_reg(CFG_SPARE_7, 10'h2AA);
                end
                3: begin
                    send_idle_pct = 58;
                    recv_idle_pct = 13;
                    // shift masked to 31, above the usual range
                    set_regs(10'h3FF, 10'd1023, 10'h3FF, 10'h3FF, 10'h3FF);
                end
                4: begin
                    set_regs(10'd0, 10'd1023, 10'd128, 10'd0, 10'd0);
                    hold_arm <= 1'b1;
                    flavor = LOUD_GRID;
                end
                5: flavor = LOUD_GRID;
                6: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    set_regs(10'd3, 10'd1, 10'd1, 10'd0, 10'd1);
                end
                7: set_regs(10'($urandom_range(24)), 10'($urandom_range(1023)),
                            10'($urandom_range(255)), 10'($urandom_range(1)),
                            10'($urandom_range(1)));
                default: ;
            endcase
            // one grid of all-quiet weights for a zero sum in bilinear mode
            if (g == 6) flavor = QUIET_GRID;
            for (int n = 0; n < NUM_POINTS; n++) begin
                if (g == 0 && n < 12) send_sample(corner[n]);
                else send_sample(pick_sample(flavor));
            end
            if (g == 6) begin
                drain();
                for (int n = 0; n < NUM_POINTS; n++) send_sample(pick_sample(MIX_GRID));
            end
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- haar_gradient_descriptor_binning_unit.f -----
design/hgdb_pkg.sv
design/hgdb_ctrl.sv
design/hgdb_dp.sv
design/haar_gradient_descriptor_binning_unit.sv
sim/hgdb_checker.sv
sim/tb_haar_gradient_descriptor_binning_unit.sv
